// ----- src/prid_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// prid_pkg: shared types and constants of the palette run-length image decoder
// no dependencies; used by every module in src

package prid_pkg;

  // input command codes
  localparam logic CMD_PALETTE = 1'b0;
  localparam logic CMD_DATA    = 1'b1;

  // stream constants
  localparam logic [7:0]  RUN_MARK   = 8'hC0;
  localparam logic [15:0] PIXEL_FLAG = 16'h8000;

  // configuration registers
  localparam int unsigned  CFG_INDEX_W      = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);
  localparam logic [15:0] WIDTH_RESET  = 16'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // default sizes
  localparam int unsigned PALETTE_ENTRIES_DEFAULT = 256;
  localparam int unsigned QUEUE_DEPTH_DEFAULT     = 4;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic [7:0] palette_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } prid_in_t;

  typedef struct packed {
    logic [15:0] pixel;
    logic [15:0] column;
    logic [15:0] row;
    logic        last_of_run;
    logic        end_of_line;
    logic        end_of_image;
  } prid_out_t;

  // work for the back end
  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXELS    = 1'b1
  } prid_op_kind_e;

  typedef struct packed {
    prid_op_kind_e kind;
    logic          in_range;  // palette index inside the store
    logic [7:0]    index;
    logic [14:0]   colour;    // rgb555, palette writes only
    logic [5:0]    count;     // pixels to emit, 1..63
  } prid_op_t;

endpackage

`default_nettype wire

// ----- src/prid_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// prid_front: accepts input items, tracks the pending run and turns items into ops
// depends on prid_pkg

module prid_front #(
  parameter int unsigned PALETTE_ENTRIES = prid_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire prid_pkg::prid_in_t in_item_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output prid_pkg::prid_op_t     q_op_o
);

  logic       run_pending_q, run_pending_d;
  logic [5:0] run_len_q, run_len_d;
  logic       accept;
  logic       is_run_start;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_run_start = (in_item_i.data_byte > prid_pkg::RUN_MARK) && !run_pending_q;

  // classify the item
  always_comb begin
    run_pending_d = run_pending_q;
    run_len_d     = run_len_q;
    q_push_o      = 1'b0;
    q_op_o.kind     = prid_pkg::OP_PIXELS;
    q_op_o.index    = in_item_i.data_byte;
    q_op_o.in_range = ({1'b0, in_item_i.data_byte} < 9'(PALETTE_ENTRIES));
    q_op_o.colour   = {in_item_i.red[7:3], in_item_i.green[7:3], in_item_i.blue[7:3]};
    q_op_o.count    = 6'd1;
    if (in_item_i.cmd == prid_pkg::CMD_PALETTE) begin
      q_op_o.kind     = prid_pkg::OP_PAL_WRITE;
      q_op_o.index    = in_item_i.palette_index;
      q_op_o.in_range = ({1'b0, in_item_i.palette_index} < 9'(PALETTE_ENTRIES));
      q_push_o        = accept;
    end else if (run_pending_q) begin
      q_op_o.count = run_len_q;
      q_push_o     = accept;
      if (accept) begin
        run_pending_d = 1'b0;
        run_len_d     = 6'd0;
      end
    end else if (is_run_start) begin
      // run length is the byte minus the run mark
      if (accept) begin
        run_pending_d = 1'b1;
        run_len_d     = in_item_i.data_byte[5:0];
      end
    end else begin
      q_push_o = accept;
    end
  end

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pending_q <= 1'b0;
      run_len_q     <= 6'd0;
    end else begin
      run_pending_q <= run_pending_d;
      run_len_q     <= run_len_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/prid_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// prid_queue: small op queue between the front and back ends
// depends on prid_pkg

module prid_queue #(
  parameter int unsigned DEPTH = prid_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire prid_pkg::prid_op_t push_op_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output prid_pkg::prid_op_t     head_op_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  prid_pkg::prid_op_t entries_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o    = (count_q == CntW'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign head_op_o = entries_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_op_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- src/prid_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// prid_back: palette store and pixel emitter with line and image position
// depends on prid_pkg

module prid_back #(
  parameter int unsigned PALETTE_ENTRIES = prid_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire prid_pkg::prid_op_t  q_op_i,
  output logic                    q_pop_o,
  input  wire logic [15:0]        image_width_i,
  input  wire logic [15:0]        image_height_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output prid_pkg::prid_out_t      out_item_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic [14:0] palette_mem [PALETTE_ENTRIES];
  logic [14:0] rd_data_q;
  logic        rd_valid_q;

  logic        state_q, state_d;
  logic [5:0]  count_q, count_d;
  logic [15:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic        out_valid_q, out_valid_d;
  prid_pkg::prid_out_t out_q, out_d;

  logic        emit;
  logic        eol, eoi, last;
  logic [AddrW-1:0] addr;

  assign addr    = q_op_i.index[AddrW-1:0];
  assign q_pop_o = (state_q == ST_IDLE) && !q_empty_i;
  assign emit    = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // palette store: write on palette ops, registered read on pixel ops
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_op_i.in_range) begin
      if (q_op_i.kind == prid_pkg::OP_PAL_WRITE) begin
        palette_mem[addr] <= q_op_i.colour;
      end else begin
        rd_data_q <= palette_mem[addr];
      end
    end
    if (q_pop_o) begin
      rd_valid_q <= q_op_i.in_range;
    end
  end

  // line and image end of the pixel at the current position
  assign eol  = ({1'b0, col_q} + 17'd1) >= {1'b0, image_width_i};
  assign eoi  = eol && (({1'b0, row_q} + 17'd1) >= {1'b0, image_height_i});
  assign last = (count_q == 6'd1) || eol;

  // sequencing and position tracking
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    col_d       = col_q;
    row_d       = row_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_IDLE: begin
        if (q_pop_o && (q_op_i.kind == prid_pkg::OP_PIXELS)) begin
          state_d = ST_EMIT;
          count_d = q_op_i.count;
        end
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_d        = 1'b1;
          out_d.pixel        = rd_valid_q ? (prid_pkg::PIXEL_FLAG | {1'b0, rd_data_q})
                                          : prid_pkg::PIXEL_FLAG;
          out_d.column       = col_q;
          out_d.row          = row_q;
          out_d.last_of_run  = last;
          out_d.end_of_line  = eol;
          out_d.end_of_image = eoi;
          count_d            = count_q - 6'd1;
          if (eol) begin
            col_d = 16'd0;
            row_d = eoi ? 16'd0 : row_q + 16'd1;
          end else begin
            col_d = col_q + 16'd1;
          end
          if (last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= 6'd0;
      col_q       <= 16'd0;
      row_q       <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      col_q       <= col_d;
      row_q       <= row_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a run in progress always has pixels left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (count_q != 6'd0))
    else $error("emitting with zero pixels left");

  // an image end is also a line end, and a line end closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.end_of_image) |-> (out_q.end_of_line && out_q.last_of_run))
    else $error("image end without line end and run end");

  // no new op is taken while a run is still emitting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !q_pop_o)
    else $error("op popped during emission");

  // a line end returns the column to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && eol) |=> (col_q == 16'd0))
    else $error("column not cleared after line end");

endmodule

`default_nettype wire

// ----- src/palette_rle_image_decoder_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Palette run-length image decoder. Input items are palette writes (RGB888 stored
// as RGB555) or bytes of a PCX-style stream; a byte above 0xC0 opens a run whose
// colour comes from the next data byte, any other byte is one pixel. Runs are clipped
// at the line end. Each pixel leaves with bit 15 set, its column and row, and run,
// line and image end flags. The front end takes one item per cycle into a four-entry
// op queue while the queue is not full; the back end pops a palette write and stores
// it, and on a pixel op first reads the palette memory into a register, then emits
// its pixels (fewer than the run length when clipped at the line end) into the output
// register while the output is ready; it pops no new op until the last pixel is out.
// Output stalls hold the emission. Run-opening bytes cost nothing in the back end.
// Configuration writes are always ready and take effect at once; the position is not
// moved. Depends on prid_pkg, prid_front, prid_queue and prid_back.

module palette_rle_image_decoder_core #(
  parameter int unsigned PALETTE_ENTRIES = prid_pkg::PALETTE_ENTRIES_DEFAULT,
  parameter int unsigned QUEUE_DEPTH     = prid_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire prid_pkg::prid_in_t                in_item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output prid_pkg::prid_out_t                    out_item_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [prid_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [15:0]                      cfg_data_i
);

  logic [15:0] width_q, height_q;
  logic        q_push, q_pop, q_full, q_empty;
  prid_pkg::prid_op_t push_op, head_op;

  // configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= prid_pkg::WIDTH_RESET;
      height_q <= prid_pkg::HEIGHT_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == prid_pkg::REG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i;
      end else if (cfg_index_i == prid_pkg::REG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  // front end
  prid_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (push_op)
  );

  // op queue
  prid_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .empty_o   (q_empty),
    .head_op_o (head_op)
  );

  // back end
  prid_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_op_i         (head_op),
    .q_pop_o        (q_pop),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_item_o     (out_item_o)
  );

endmodule

`default_nettype wire

// ----- sim/prid_pixel_checker.sv -----
`timescale 1ns / 1ps
// prid_pixel_checker: watches the decoder's input, output and register channels,
// predicts every pixel from the accepted items and compares it with the output
// depends on prid_pkg

module prid_pixel_checker
  import prid_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEFAULT,
  parameter int unsigned REPORT_LIMIT    = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  prid_in_t               in_item_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  prid_out_t              out_item_i,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [15:0]            cfg_data_i,
  output int unsigned            pixels_due_o,
  output int unsigned            pixels_seen_o,
  output int unsigned            mismatches_o
);

  // predicted decoder state
  logic [14:0] colour_mem [PALETTE_ENTRIES];
  logic [15:0] line_width;
  logic [15:0] line_count;
  logic        run_armed;
  logic [5:0]  run_len;
  logic [15:0] col_pos;
  logic [15:0] row_pos;
  prid_out_t   expected_pixels [$];
  int unsigned mismatch_count;
  int unsigned seen_count;

  // palette lookup with the pixel flag set; indexes past the store read as black
  function automatic logic [15:0] lookup_colour(logic [7:0] idx);
    if (int'(idx) < PALETTE_ENTRIES) begin
      return PIXEL_FLAG | {1'b0, colour_mem[idx]};
    end
    return PIXEL_FLAG;
  endfunction

  // one pixel at the current position, then advance column and row
  task automatic place_pixel(logic [15:0] colour, logic last);
    prid_out_t px;
    px.pixel        = colour;
    px.column       = col_pos;
    px.row          = row_pos;
    px.last_of_run  = last;
    px.end_of_line  = (17'(col_pos) + 17'd1) >= 17'(line_width);
    px.end_of_image = 1'b0;
    if (px.end_of_line) begin
      px.end_of_image = (17'(row_pos) + 17'd1) >= 17'(line_count);
      col_pos = '0;
      row_pos = px.end_of_image ? 16'd0 : row_pos + 16'd1;
    end else begin
      col_pos = col_pos + 16'd1;
    end
    expected_pixels.push_back(px);
  endtask

  // expected pixels of one accepted item
  task automatic decode_item(prid_in_t it);
    logic [15:0] colour;
    logic        closes;
    int unsigned k;
    if (it.cmd == CMD_PALETTE) begin
      if (int'(it.palette_index) < PALETTE_ENTRIES) begin
        colour_mem[it.palette_index] = {it.red[7:3], it.green[7:3], it.blue[7:3]};
      end
    end else if (run_armed) begin
      // colour byte of a pending run; the run stops at the line end
      colour    = lookup_colour(it.data_byte);
      run_armed = 1'b0;
      for (k = 0; k < run_len; k++) begin
        closes = (17'(col_pos) + 17'd1) >= 17'(line_width);
        place_pixel(colour, (k + 1 == run_len) || closes);
        if (closes) break;
      end
      run_len = '0;
    end else if (it.data_byte > RUN_MARK) begin
      run_armed = 1'b1;
      run_len   = 6'(it.data_byte - RUN_MARK);
    end else begin
      place_pixel(lookup_colour(it.data_byte), 1'b1);
    end
  endtask

  // compare outputs, follow register writes, predict from inputs
  always @(posedge clk_i or negedge rst_ni) begin : track
    prid_out_t want;
    if (!rst_ni) begin
      for (int i = 0; i < PALETTE_ENTRIES; i++) colour_mem[i] = '0;
      line_width     = WIDTH_RESET;
      line_count     = HEIGHT_RESET;
      run_armed      = 1'b0;
      run_len        = '0;
      col_pos        = '0;
      row_pos        = '0;
      mismatch_count = 0;
      seen_count     = 0;
      expected_pixels.delete();
      pixels_due_o  <= 0;
      pixels_seen_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("unexpected pixel %h at column %0d row %0d", out_item_i.pixel,
                     out_item_i.column, out_item_i.row);
          end
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          seen_count++;
          if (out_item_i.pixel !== want.pixel || out_item_i.column !== want.column ||
              out_item_i.row !== want.row || out_item_i.last_of_run !== want.last_of_run ||
              out_item_i.end_of_line !== want.end_of_line ||
              out_item_i.end_of_image !== want.end_of_image) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display("pixel mismatch: expected %h col %0d row %0d last %b eol %b eoi %b",
                       want.pixel, want.column, want.row, want.last_of_run,
                       want.end_of_line, want.end_of_image);
              $display("                got      %h col %0d row %0d last %b eol %b eoi %b",
                       out_item_i.pixel, out_item_i.column, out_item_i.row,
                       out_item_i.last_of_run, out_item_i.end_of_line,
                       out_item_i.end_of_image);
            end
            mismatch_count++;
          end
        end
      end
      // register writes; unknown indexes leave everything as it is
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_IMAGE_WIDTH) begin
          line_width = cfg_data_i;
        end else if (cfg_index_i == REG_IMAGE_HEIGHT) begin
          line_count = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        decode_item(in_item_i);
      end
      pixels_due_o  <= expected_pixels.size();
      pixels_seen_o <= seen_count;
      mismatches_o  <= mismatch_count;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: drives palette writes, literal bytes and runs into the decoder core
// under random stalls and several image sizes; depends on prid_pkg,
// palette_rle_image_decoder_core and prid_pixel_checker

module tb_top;
  import prid_pkg::*;

  localparam int unsigned    RANDOM_ITEMS  = 150;
  localparam int unsigned    SETTLE_CYCLES = 16;
  // bound for ~190 items of up to 63 pixels, each pixel behind the longest output stall
  localparam longint unsigned CYCLE_LIMIT  = 3_000_000;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  prid_in_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  prid_out_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data  = '0;

  int unsigned     pixels_due;
  int unsigned     pixels_seen;
  int unsigned     mismatches;
  int unsigned     items_sent     = 0;
  int unsigned     palette_writes = 0;
  int unsigned     reg_writes     = 0;
  int unsigned     stall_left     = 0;
  longint unsigned cycle_count    = 0;
  logic            no_gaps        = 1'b0;

  // palette entries written so far; only those are ever read
  bit         entry_set [256];
  logic [7:0] known_entries [$];

  palette_rle_image_decoder_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  prid_pixel_checker pixel_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .pixels_due_o  (pixels_due),
    .pixels_seen_o (pixels_seen),
    .mismatches_o  (mismatches)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still due", cycle_count, pixels_due);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // output side: mostly ready, short stalls and a few long ones
  always @(posedge clk) begin : pixel_sink
    int unsigned roll;
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (no_gaps) begin
      out_ready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left <= (roll < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
      end
    end
  end

  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic prid_in_t palette_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                            logic [7:0] b);
    prid_in_t it;
    it.cmd           = CMD_PALETTE;
    it.data_byte     = 8'($urandom);
    it.palette_index = idx;
    it.red           = r;
    it.green         = g;
    it.blue          = b;
    return it;
  endfunction

  function automatic prid_in_t data_item(logic [7:0] code);
    prid_in_t it;
    it.cmd           = CMD_DATA;
    it.data_byte     = code;
    it.palette_index = 8'($urandom);
    it.red           = 8'($urandom);
    it.green         = 8'($urandom);
    it.blue          = 8'($urandom);
    return it;
  endfunction

  // a written entry; literal bytes must stay at or below the run mark
  function automatic logic [7:0] pick_index(bit literal_only);
    logic [7:0] idx;
    do idx = known_entries[$urandom_range(0, known_entries.size() - 1)];
    while (literal_only && idx > RUN_MARK);
    return idx;
  endfunction

  // one item, with a random gap in front of it
  task automatic send_item(prid_in_t it);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (it.cmd == CMD_PALETTE) begin
      palette_writes++;
      if (!entry_set[it.palette_index]) begin
        entry_set[it.palette_index] = 1'b1;
        known_entries.push_back(it.palette_index);
      end
    end
  endtask

  // stop sending, wait for every due pixel, then let queued palette writes drain
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pixels_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic set_size(logic [15:0] w, logic [15:0] h);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // mostly well-formed literals and runs, with palette updates mixed in
  task automatic random_phase(int unsigned n);
    int unsigned done;
    int unsigned roll;
    logic [5:0]  len;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        send_item(palette_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
        done++;
      end else if (roll < 50) begin
        len = (roll < 42) ? 6'($urandom_range(1, 8)) : 6'($urandom_range(9, 63));
        send_item(data_item(RUN_MARK + 8'(len)));
        if ($urandom_range(0, 9) == 0) begin
          send_item(palette_item(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)));
          done++;
        end
        send_item(data_item(pick_index(1'b0)));
        done += 2;
      end else begin
        send_item(data_item(pick_index(1'b1)));
        done++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    int unsigned first_random;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // palette extremes and bit patterns
    send_item(palette_item(8'h00, 8'hFF, 8'hFF, 8'hFF));
    send_item(palette_item(8'hFF, 8'h00, 8'h00, 8'h00));
    send_item(palette_item(RUN_MARK, 8'hF8, 8'h07, 8'hA5));
    send_item(palette_item(8'h55, 8'h07, 8'hF8, 8'h5A));
    send_item(palette_item(8'hAA, 8'h80, 8'h7F, 8'hC3));
    // single pixels, the run mark itself among them
    send_item(data_item(8'h00));
    send_item(data_item(RUN_MARK));
    send_item(data_item(8'h55));
    // shortest run, colour byte above the mark
    send_item(data_item(RUN_MARK + 8'd1));
    send_item(data_item(8'hFF));
    // longest run, its colour rewritten while the run waits
    send_item(data_item(8'hFF));
    send_item(palette_item(8'hAA, 8'h3C, 8'hC3, 8'h99));
    send_item(data_item(8'hAA));
    // column is 67 now: an 8 pixel run gets clipped at the end of a 70 pixel line
    set_size(16'd70, HEIGHT_RESET);
    send_item(data_item(RUN_MARK + 8'd8));
    send_item(data_item(8'h55));
    // width drops below the position mid-line: the run yields a single pixel
    repeat (3) send_item(data_item(8'h00));
    set_size(16'd2, HEIGHT_RESET);
    send_item(data_item(RUN_MARK + 8'd5));
    send_item(data_item(8'h00));
    send_item(data_item(RUN_MARK));
    // row past a lowered height: the next line end closes the image
    set_size(16'd2, 16'd1);
    send_item(data_item(8'h55));
    // unknown register indexes are ignored
    settle();
    write_reg(CFG_INDEX_W'(2), 16'h0001);
    write_reg('1, 16'hFFFF);
    // one pixel images
    set_size(16'd1, 16'd1);
    send_item(data_item(8'h00));

    // random part over a range of image sizes
    first_random = items_sent;
    for (phase = 0; items_sent - first_random < RANDOM_ITEMS; phase++) begin
      case (phase)
        0:       set_size(16'd1, 16'd1);
        1:       set_size(16'd5, 16'd3);
        2:       set_size(16'd2, 16'hFFFF);
        3:       set_size(16'hFFFF, 16'd2);
        4:       set_size(16'hFFFF, 16'hFFFF);
        5:       set_size(16'd1, 16'hFFFF);
        6:       set_size(16'd13, 16'd4);
        7:       set_size(WIDTH_RESET, HEIGHT_RESET);
        default: set_size(16'($urandom_range(1, 24)), 16'($urandom_range(1, 6)));
      endcase
      no_gaps <= ($urandom_range(0, 3) == 0);
      random_phase(22);
    end

    settle();
    repeat (64) @(posedge clk);
    $display("run: %0d items (%0d palette writes), %0d pixels compared, %0d register writes",
             items_sent, palette_writes, pixels_seen, reg_writes);
    $display("run: image sizes 1x1 to 65535x65535, clipped runs, mid-line size changes");
    if (mismatches == 0 && pixels_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- palette_rle_image_decoder_core.f -----
src/prid_pkg.sv
src/prid_front.sv
src/prid_queue.sv
src/prid_back.sv
src/palette_rle_image_decoder_core.sv
sim/prid_pixel_checker.sv
sim/tb_top.sv
